[sv/assert_macros.svh]
// Assertion macros shared by the pcm sample quantize packer RTL.
// Needs clk and rst in scope where used; define NO_ASSERTIONS to drop them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define PCMSQ_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pcmsq assertion failed");
`define PCMSQ_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pcmsq assertion failed");
`else
`define PCMSQ_ASSERT_IMP(label, ante, cons)
`define PCMSQ_ASSERT_NXT(label, ante, cons)
`endif
`endif

[sv/pcmsq_pkg.sv]
// Shared constants, types and quantizer helpers for the sample packer.
// No dependencies.
package pcmsq_pkg;

  localparam int INPUT_FRAC_BITS = 30;
  localparam int WORK_FRAC = INPUT_FRAC_BITS + 1;
  localparam int MAG_W = WORK_FRAC + 1;
  localparam int FS_W = 31;
  localparam int PROD_W = MAG_W + FS_W;
  localparam logic signed [32:0] LIM = 33'sd1 <<< WORK_FRAC;
  localparam logic [PROD_W-1:0] ROUND = PROD_W'(1) << (WORK_FRAC - 1);

  localparam int QDEPTH = 8;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = QPTR_W + 1;

  localparam logic [1:0] CH_MONO = 2'd1;

  typedef enum logic [1:0] {
    REG_CHANNEL_COUNT = 2'd0,
    REG_SLOT_BYTES    = 2'd1,
    REG_SAMPLE_BITS   = 2'd2
  } reg_index_t;

  typedef struct packed {
    logic [2:0] slot;
    logic [4:0] lsh;
    logic       mono;
    logic       last;
  } lane_ctl_t;

  typedef struct packed {
    logic [63:0] bytes;
    logic [3:0]  total;
    logic        last;
  } frame_t;

  // {neg, magnitude} of a working sample clipped to +/- 2^WORK_FRAC
  function automatic logic [MAG_W:0] clip_mag(input logic signed [32:0] v);
    logic signed [32:0] c;
    logic signed [32:0] a;
    c = v;
    if (c > LIM) c = LIM;
    if (c < -LIM) c = -LIM;
    a = c[32] ? -c : c;
    return {c[32], a[MAG_W-1:0]};
  endfunction

  // round half away from zero, restore sign, left-align in the slot
  function automatic logic [31:0] q_word(input logic [PROD_W-1:0] prod,
                                         input logic neg, input logic [4:0] lsh);
    logic [PROD_W-1:0] s;
    logic [31:0] w;
    s = prod + ROUND;
    w = {1'b0, s[WORK_FRAC+FS_W-1:WORK_FRAC]};
    if (neg) w = 32'd0 - w;
    return w << lsh;
  endfunction

endpackage

[sv/pcmsq_front.sv]
// Front end: config registers, frame intake with credit check, quantizer pipeline.
// Depends on pcmsq_pkg.
module pcmsq_front (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_valid,
  input  logic [1:0]                  cfg_index,
  input  logic [5:0]                  cfg_data,
  input  logic                        frame_valid,
  output logic                        frame_stall,
  input  logic signed [31:0]          left_sample,
  input  logic signed [31:0]          right_sample,
  input  logic                        last_frame,
  input  logic [pcmsq_pkg::QCNT_W-1:0] q_count,
  output logic                        push,
  output pcmsq_pkg::frame_t           push_data
);

  logic [1:0] channel_count;
  logic [2:0] slot_bytes;
  logic [5:0] sample_bits;

  always_ff @(posedge clk) begin
    if (rst) begin
      channel_count <= 2'd2;
      slot_bytes    <= 3'd2;
      sample_bits   <= 6'd16;
    end else if (cfg_valid) begin
      unique case (pcmsq_pkg::reg_index_t'(cfg_index))
        pcmsq_pkg::REG_CHANNEL_COUNT: channel_count <= cfg_data[1:0];
        pcmsq_pkg::REG_SLOT_BYTES:    slot_bytes    <= cfg_data[2:0];
        pcmsq_pkg::REG_SAMPLE_BITS:   sample_bits   <= cfg_data;
        default: ;
      endcase
    end
  end

  // intake decode
  logic [2:0]  slot_eff;
  logic [5:0]  bits_lo, bits_eff, cap;
  logic [31:0] fs_full;
  logic signed [32:0] w0, w1;
  logic [pcmsq_pkg::MAG_W:0] c0, c1;
  logic [1:0] inflight;
  logic [pcmsq_pkg::QCNT_W:0] credit;
  logic accept;
  logic mono;

  always_comb begin
    case (slot_bytes)
      3'd0: slot_eff = 3'd1;
      3'd5, 3'd6, 3'd7: slot_eff = 3'd4;
      default: slot_eff = slot_bytes;
    endcase
    cap      = {slot_eff, 3'b000};
    bits_lo  = (sample_bits < 6'd8) ? 6'd8 : sample_bits;
    bits_eff = (bits_lo > cap) ? cap : bits_lo;
    fs_full  = (32'd1 << (bits_eff - 6'd1)) - 32'd1;
    mono     = (channel_count == pcmsq_pkg::CH_MONO);
    w0 = mono ? (33'(left_sample) + 33'(right_sample)) : (33'(left_sample) + 33'(left_sample));
    w1 = 33'(right_sample) + 33'(right_sample);
    c0 = pcmsq_pkg::clip_mag(w0);
    c1 = pcmsq_pkg::clip_mag(w1);
  end

  // pipeline stages
  logic v1, v2, v3;
  logic [pcmsq_pkg::MAG_W-1:0] mag0, mag1;
  logic n1_0, n1_1, n2_0, n2_1;
  logic [pcmsq_pkg::FS_W-1:0] fs;
  pcmsq_pkg::lane_ctl_t ctl1, ctl2, ctl3;
  logic [pcmsq_pkg::PROD_W-1:0] prod0, prod1;
  logic [31:0] word0, word1;

  assign inflight = 2'(v1) + 2'(v2) + 2'(v3);
  assign credit = (pcmsq_pkg::QCNT_W+1)'(q_count) + (pcmsq_pkg::QCNT_W+1)'(inflight);
  assign frame_stall = (credit >= (pcmsq_pkg::QCNT_W+1)'(pcmsq_pkg::QDEPTH));
  assign accept = frame_valid && !frame_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v1 <= accept;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    mag0 <= c0[pcmsq_pkg::MAG_W-1:0];
    mag1 <= c1[pcmsq_pkg::MAG_W-1:0];
    n1_0 <= c0[pcmsq_pkg::MAG_W];
    n1_1 <= c1[pcmsq_pkg::MAG_W];
    fs   <= fs_full[pcmsq_pkg::FS_W-1:0];
    ctl1 <= '{slot: slot_eff, lsh: 5'(cap - bits_eff), mono: mono, last: last_frame};

    prod0 <= pcmsq_pkg::PROD_W'(mag0) * pcmsq_pkg::PROD_W'(fs);
    prod1 <= pcmsq_pkg::PROD_W'(mag1) * pcmsq_pkg::PROD_W'(fs);
    n2_0  <= n1_0;
    n2_1  <= n1_1;
    ctl2  <= ctl1;

    word0 <= pcmsq_pkg::q_word(prod0, n2_0, ctl2.lsh);
    word1 <= pcmsq_pkg::q_word(prod1, n2_1, ctl2.lsh);
    ctl3  <= ctl2;
  end

  // pack slot bytes into one little-endian word stream
  logic [63:0] low;
  always_comb begin
    case (ctl3.slot)
      3'd1: low = {56'd0, word0[7:0]};
      3'd2: low = {48'd0, word0[15:0]};
      3'd3: low = {40'd0, word0[23:0]};
      default: low = {32'd0, word0};
    endcase
    push = v3;
    push_data.last = ctl3.last;
    if (ctl3.mono) begin
      push_data.bytes = low;
      push_data.total = {1'b0, ctl3.slot};
    end else begin
      push_data.bytes = low | ({32'd0, word1} << {ctl3.slot, 3'b000});
      push_data.total = {ctl3.slot, 1'b0};
    end
  end

endmodule

[sv/pcmsq_queue.sv]
// Frame queue between the quantizer front end and the byte serializer.
// Depends on pcmsq_pkg.
module pcmsq_queue (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         push,
  input  pcmsq_pkg::frame_t            push_data,
  input  logic                         pop,
  output pcmsq_pkg::frame_t            head,
  output logic [pcmsq_pkg::QCNT_W-1:0] count
);

  pcmsq_pkg::frame_t mem [pcmsq_pkg::QDEPTH];
  logic [pcmsq_pkg::QPTR_W-1:0] wr_ptr, rd_ptr;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      count <= count + pcmsq_pkg::QCNT_W'(push) - pcmsq_pkg::QCNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_data;
  end

  assign head = mem[rd_ptr];

endmodule

[sv/pcmsq_back.sv]
// Back end: walks the queue head one byte per word and drives the output register.
// Depends on pcmsq_pkg.
module pcmsq_back (
  input  logic                         clk,
  input  logic                         rst,
  input  pcmsq_pkg::frame_t            head,
  input  logic [pcmsq_pkg::QCNT_W-1:0] count,
  output logic                         pop,
  output logic                         byte_valid,
  input  logic                         byte_stall,
  output logic [7:0]                   out_byte,
  output logic                         end_of_frame,
  output logic                         end_of_packet
);

  logic [2:0] pos, pos_next;
  logic load, eof;

  always_comb begin
    load     = (count != '0) && (!byte_valid || !byte_stall);
    eof      = ({1'b0, pos} + 4'd1 == head.total);
    pop      = load && eof;
    pos_next = pos;
    if (load) pos_next = eof ? 3'd0 : pos + 3'd1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos        <= 3'd0;
      byte_valid <= 1'b0;
    end else begin
      pos <= pos_next;
      if (load) byte_valid <= 1'b1;
      else if (!byte_stall) byte_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte      <= head.bytes[{pos, 3'b000} +: 8];
      end_of_frame  <= eof;
      end_of_packet <= eof && head.last;
    end
  end

endmodule

[sv/pcm_sample_quantize_packer.sv]
// Quantizes a stereo Q2.30 frame (or its mono average) to 8..32-bit PCM in 1..4-byte slots
// and streams it little-endian, one byte word per cycle while byte_stall is low. A frame can be
// accepted every cycle while frame_stall is low; it passes the three quantizer stages and the
// frame queue before the output register, and a frame is slot_bytes x channels byte words
// (1 to 8). An 8-entry frame queue lets intake run ahead while the output is stalled; intake
// stalls once the queue and the three quantizer stages hold eight frames. Depends on
// pcmsq_pkg and the sub-blocks.
`include "assert_macros.svh"
module pcm_sample_quantize_packer (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [5:0]         cfg_data,
  input  logic               frame_valid,
  output logic               frame_stall,
  input  logic signed [31:0] left_sample,
  input  logic signed [31:0] right_sample,
  input  logic               last_frame,
  output logic               byte_valid,
  input  logic               byte_stall,
  output logic [7:0]         out_byte,
  output logic               end_of_frame,
  output logic               end_of_packet
);

  logic push, pop;
  pcmsq_pkg::frame_t push_data, head;
  logic [pcmsq_pkg::QCNT_W-1:0] q_count;

  assign cfg_ready = 1'b1;

  pcmsq_front u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .frame_valid  (frame_valid),
    .frame_stall  (frame_stall),
    .left_sample  (left_sample),
    .right_sample (right_sample),
    .last_frame   (last_frame),
    .q_count      (q_count),
    .push         (push),
    .push_data    (push_data)
  );

  pcmsq_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .count     (q_count)
  );

  pcmsq_back u_back (
    .clk           (clk),
    .rst           (rst),
    .head          (head),
    .count         (q_count),
    .pop           (pop),
    .byte_valid    (byte_valid),
    .byte_stall    (byte_stall),
    .out_byte      (out_byte),
    .end_of_frame  (end_of_frame),
    .end_of_packet (end_of_packet)
  );

  `PCMSQ_ASSERT_IMP(a_no_overflow, push && !pop, q_count < pcmsq_pkg::QCNT_W'(pcmsq_pkg::QDEPTH))
  `PCMSQ_ASSERT_IMP(a_no_underflow, pop, q_count != '0)
  `PCMSQ_ASSERT_NXT(a_count_up, push && !pop, q_count == $past(q_count) + 1'b1)
  `PCMSQ_ASSERT_IMP(a_eop_on_eof, byte_valid && end_of_packet, end_of_frame)

endmodule

[tb/tb.sv]
// Self-checking bench for pcm_sample_quantize_packer: random and directed stereo frames
// against a local quantizer/packer model of every byte word. Depends on pcmsq_pkg and the RTL.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] REG_UNUSED = 2'd3;
  localparam int HOLD_CYCLES = 120;

  typedef struct {
    logic signed [31:0] left;
    logic signed [31:0] right;
    logic               last;
  } frame_in_t;

  typedef struct {
    logic [7:0] data;
    logic       eof;
    logic       eop;
  } pcm_byte_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [1:0]         cfg_index = 2'd0;
  logic [5:0]         cfg_data = 6'd0;
  logic               frame_valid = 1'b0;
  logic               frame_stall;
  logic signed [31:0] left_sample = 32'sd0;
  logic signed [31:0] right_sample = 32'sd0;
  logic               last_frame = 1'b0;
  logic               byte_valid;
  logic               byte_stall = 1'b0;
  logic [7:0]         out_byte;
  logic               end_of_frame;
  logic               end_of_packet;

  // local copy of the block's registers
  logic [1:0] cfg_ch = 2'd2;
  logic [2:0] cfg_slot = 3'd2;
  logic [5:0] cfg_bits = 6'd16;

  frame_in_t frame_src_q[$];
  pcm_byte_t pending_bytes[$];

  int snd_idle_pct = 0;
  int rcv_idle_pct = 0;
  logic hold_go = 1'b0;
  int hold_left = 0;

  int err_cnt = 0;
  int frames_sent = 0;
  int bytes_seen = 0;
  int cfg_writes = 0;

  pcm_sample_quantize_packer u_top (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .frame_valid   (frame_valid),
    .frame_stall   (frame_stall),
    .left_sample   (left_sample),
    .right_sample  (right_sample),
    .last_frame    (last_frame),
    .byte_valid    (byte_valid),
    .byte_stall    (byte_stall),
    .out_byte      (out_byte),
    .end_of_frame  (end_of_frame),
    .end_of_packet (end_of_packet)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic note_mismatch(input string msg);
    $display("mismatch @%0t: %s", $realtime, msg);
    err_cnt++;
  endtask

  // clip to [-1,1] (31 fraction bits), scale, round half away from zero, left-align
  function automatic logic [31:0] quantize_to_word(input longint v, input int unsigned bits,
                                                   input int unsigned slot);
    longint lim, mag, fs, q;
    logic [31:0] w;
    lim = longint'(1) << 31;
    if (v > lim) v = lim;
    if (v < -lim) v = -lim;
    mag = (v < 0) ? -v : v;
    fs = (longint'(1) << (bits - 1)) - 1;
    q = (mag * fs + (longint'(1) << 30)) >>> 31;
    w = q[31:0];
    if (v < 0) w = 32'd0 - w;
    return w << (slot * 8 - bits);
  endfunction

  task automatic pack_frame(input logic signed [31:0] l, input logic signed [31:0] r,
                            input logic lst);
    int unsigned slot, bits, nslots, total, n;
    logic [31:0] words[2];
    pcm_byte_t b;
    slot = cfg_slot;
    bits = cfg_bits;
    n = 0;
    if (slot < 1) slot = 1;
    if (slot > 4) slot = 4;
    if (bits < 8) bits = 8;
    if (bits > slot * 8) bits = slot * 8;
    if (cfg_ch == pcmsq_pkg::CH_MONO) begin
      words[0] = quantize_to_word(longint'(l) + longint'(r), bits, slot);
      nslots = 1;
    end else begin
      words[0] = quantize_to_word(2 * longint'(l), bits, slot);
      words[1] = quantize_to_word(2 * longint'(r), bits, slot);
      nslots = 2;
    end
    total = nslots * slot;
    for (int k = 0; k < nslots; k++) begin
      for (int j = 0; j < slot; j++) begin
        b.data = words[k][8*j +: 8];
        b.eof = (n + 1 == total);
        b.eop = b.eof && lst;
        pending_bytes.push_back(b);
        n++;
      end
    end
  endtask

  // frame driver
  always @(posedge clk) begin : frame_drv
    frame_in_t nxt;
    if (rst) begin
      frame_valid <= 1'b0;
    end else if (!frame_valid || !frame_stall) begin
      if (frame_valid) begin
        pack_frame(left_sample, right_sample, last_frame);
        frames_sent++;
      end
      if (frame_src_q.size() != 0 && $urandom_range(0, 99) >= snd_idle_pct) begin
        nxt = frame_src_q.pop_front();
        left_sample <= nxt.left;
        right_sample <= nxt.right;
        last_frame <= nxt.last;
        frame_valid <= 1'b1;
      end else begin
        frame_valid <= 1'b0;
      end
    end
  end

  // byte word monitor
  always @(posedge clk) begin : byte_mon
    pcm_byte_t exp_b;
    if (!rst) begin
      if (byte_valid && !byte_stall) begin
        bytes_seen++;
        if (pending_bytes.size() == 0) begin
          note_mismatch($sformatf("unexpected word %02h eof %0b eop %0b",
                                  out_byte, end_of_frame, end_of_packet));
        end else begin
          exp_b = pending_bytes.pop_front();
          if (out_byte !== exp_b.data || end_of_frame !== exp_b.eof ||
              end_of_packet !== exp_b.eop)
            note_mismatch($sformatf("word %02h/%0b/%0b, want %02h/%0b/%0b",
                                    out_byte, end_of_frame, end_of_packet,
                                    exp_b.data, exp_b.eof, exp_b.eop));
        end
      end
      byte_stall <= (hold_left != 0) || ($urandom_range(0, 99) < rcv_idle_pct);
    end
  end

  // long receiver hold-off
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
    end else if (hold_go) begin
      hold_left <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  task automatic write_reg(input logic [1:0] idx, input logic [5:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cfg_writes++;
    if (idx == pcmsq_pkg::REG_CHANNEL_COUNT) cfg_ch = val[1:0];
    else if (idx == pcmsq_pkg::REG_SLOT_BYTES) cfg_slot = val[2:0];
    else if (idx == pcmsq_pkg::REG_SAMPLE_BITS) cfg_bits = val;
  endtask

  task automatic add_frame(input logic [31:0] l, input logic [31:0] r, input logic lst);
    frame_in_t f;
    f.left = l;
    f.right = r;
    f.last = lst;
    frame_src_q.push_back(f);
  endtask

  // sampled mid-cycle so the driver's and monitor's edge updates have settled
  task automatic wait_idle();
    int guard = 0;
    while ((frame_src_q.size() != 0 || frame_valid || pending_bytes.size() != 0 ||
            hold_left != 0) && guard < 20000) begin
      @(negedge clk);
      guard++;
    end
    repeat (8) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_sample();
    logic [31:0] s;
    int sel;
    sel = $urandom_range(0, 3);
    case (sel)
      0: s = $urandom;
      1: s = 32'h4000_0000 + $urandom_range(0, 63) - 32;
      2: s = $urandom_range(0, 4095);
      default: begin
        case ($urandom_range(0, 2))
          0: s = 32'h7FFF_FFFF;
          1: s = 32'h8000_0000;
          default: s = 32'h0;
        endcase
      end
    endcase
    if ((sel == 1 || sel == 2) && $urandom_range(0, 1) == 1) s = 32'd0 - s;
    return s;
  endfunction

  initial begin
    logic [2:0] slot_v;
    logic [5:0] bits_v;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    snd_idle_pct <= 29;
    rcv_idle_pct <= 52;

    // reset settings: stereo, 2-byte slots, 16 bits
    add_frame(32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
    add_frame(32'h4000_0000, 32'hC000_0000, 1'b1);
    add_frame(32'h0000_0000, 32'hFFFF_FFFF, 1'b0);
    add_frame(32'h0000_0001, 32'h3FFF_FFFF, 1'b1);
    wait_idle();

    // mono, widest slot and sample; data bits above the field are dropped
    write_reg(pcmsq_pkg::REG_CHANNEL_COUNT, 6'b1111_01);
    write_reg(pcmsq_pkg::REG_SLOT_BYTES, 6'd4);
    write_reg(pcmsq_pkg::REG_SAMPLE_BITS, 6'd32);
    add_frame(32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
    add_frame(32'h8000_0000, 32'h8000_0000, 1'b0);
    add_frame(32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
    add_frame(32'h4000_0000, 32'h4000_0000, 1'b1);
    wait_idle();

    // unused channel code, zero slot, sample width below 8
    write_reg(pcmsq_pkg::REG_CHANNEL_COUNT, 6'd3);
    write_reg(pcmsq_pkg::REG_SLOT_BYTES, 6'd0);
    write_reg(pcmsq_pkg::REG_SAMPLE_BITS, 6'd0);
    add_frame(32'h4000_0000, 32'hC000_0000, 1'b0);
    add_frame(32'h2000_0000, 32'hDFFF_FFFF, 1'b1);
    add_frame(32'h0040_0000, 32'hFFC0_0000, 1'b0);
    wait_idle();

    // channel code 0, oversize slot, sample width too wide
    write_reg(pcmsq_pkg::REG_CHANNEL_COUNT, 6'd0);
    write_reg(pcmsq_pkg::REG_SLOT_BYTES, 6'd7);
    write_reg(pcmsq_pkg::REG_SAMPLE_BITS, 6'd63);
    add_frame(32'h7FFF_FFFF, 32'h8000_0000, 1'b1);
    add_frame(32'h1234_5678, 32'hEDCB_A988, 1'b0);
    add_frame(32'h0000_0001, 32'hFFFF_FFFF, 1'b1);
    wait_idle();

    // write to the unused index must leave everything alone
    write_reg(pcmsq_pkg::REG_CHANNEL_COUNT, {4'd0, pcmsq_pkg::CH_MONO});
    write_reg(pcmsq_pkg::REG_SLOT_BYTES, 6'd3);
    write_reg(pcmsq_pkg::REG_SAMPLE_BITS, 6'd20);
    write_reg(REG_UNUSED, 6'h3F);
    add_frame(32'h3FFF_FFFF, 32'h4000_0001, 1'b0);
    add_frame(32'hC000_0000, 32'h0000_0000, 1'b0);
    add_frame(32'h1555_5555, 32'hEAAA_AAAB, 1'b1);
    wait_idle();

    for (int seg = 0; seg < 8; seg++) begin
      if (seg == 3) begin
        snd_idle_pct <= 52;
        rcv_idle_pct <= 29;
      end else if (seg == 6) begin
        snd_idle_pct <= 0;
        rcv_idle_pct <= 0;
      end
      slot_v = ($urandom_range(0, 3) == 0) ? 3'($urandom_range(0, 7))
                                           : 3'($urandom_range(1, 4));
      bits_v = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 63))
                                           : 6'($urandom_range(8, 32));
      write_reg(pcmsq_pkg::REG_CHANNEL_COUNT,
                (seg % 2 == 0) ? {4'($urandom), pcmsq_pkg::CH_MONO}
                               : 6'($urandom_range(0, 63)));
      write_reg(pcmsq_pkg::REG_SLOT_BYTES, {3'($urandom), slot_v});
      write_reg(pcmsq_pkg::REG_SAMPLE_BITS, bits_v);
      for (int i = 0; i < 31; i++)
        add_frame(rand_sample(), rand_sample(), $urandom_range(0, 3) == 0);
      if (seg == 6) begin
        @(posedge clk);
        hold_go <= 1'b1;
        @(posedge clk);
        hold_go <= 1'b0;
      end
      wait_idle();
    end

    repeat (20) @(posedge clk);
    if (pending_bytes.size() != 0)
      note_mismatch($sformatf("%0d words never arrived", pending_bytes.size()));
    $display("run covered %0d frames and %0d byte words over %0d register writes,",
             frames_sent, bytes_seen, cfg_writes);
    $display("mono and stereo, slot and width clamps, idle mixes and a long output hold-off");
    if (err_cnt == 0) begin
      $display("[pcm_sample_quantize_packer] OK");
    end else begin
      $display("[pcm_sample_quantize_packer] ERROR");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("[pcm_sample_quantize_packer] ERROR");
    $finish;
  end

endmodule
